// ===== rtl/sprm_pkg.sv =====
// ----------------------------------------------------------------------------
// sprm_pkg
// shared types, constants and register indexes for the stereo level meter
// ----------------------------------------------------------------------------
package sprm_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int WINDOW_BITS_DEF = 16;
    localparam int SAMPLE_W        = 24;
    localparam int SUM_W           = 62;
    localparam int DECAY_W         = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    localparam logic [DECAY_W-1:0] DECAY_RESET  = 16'd65503;
    localparam logic [15:0]        WINDOW_RESET = 16'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECAY   = 2'd0,
        REG_WINDOW  = 2'd1,
        REG_CHANNEL = 2'd2,
        REG_BYPASS  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_AUDIO     = 2'd0,
        KIND_CLR_PEAK  = 2'd1,
        KIND_CLR_ALL   = 2'd2,
        KIND_NONE      = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic [SAMPLE_W-1:0]        peak_left;
        logic [SAMPLE_W-1:0]        peak_right;
        logic [SAMPLE_W-1:0]        rms_left;
        logic [SAMPLE_W-1:0]        rms_right;
        logic                       rms_updated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEAK,
        ST_DIV,
        ST_SQRT,
        ST_EMIT
    } back_state_t;

endpackage

// ===== rtl/stereo_peak_rms_meter.sv =====
// path: clears, unknown kinds and bypassed frames go from idle to emit; audio
//   frames pass the peak state; a window end adds divide and root per channel
// throughput: one request in flight in the engine, set by the serial divider
//   and square-root unit; the engine waits while its result is not popped,
//   and a two-entry queue takes requests meanwhile
// reset: rst_n clears all meter state and loads register defaults
// ----------------------------------------------------------------------------
// stereo_peak_rms_meter
// stereo peak and rms level meter with pass-through audio
// ----------------------------------------------------------------------------
module stereo_peak_rms_meter
    import sprm_pkg::*;
#(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request side
    input  logic                  push,
    input  in_item_t              in_item,
    output logic                  full,
    // result side
    output logic                  empty,
    output out_item_t             out_item,
    input  logic                  pop,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    logic [DECAY_W-1:0]     decay_reg;
    logic [WINDOW_BITS-1:0] window_reg;
    logic [1:0]             chan_reg;
    logic                   bypass_reg;

    logic     q_empty, q_take;
    in_item_t q_data;

    // config port always ready, decoded by register index
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg  <= DECAY_RESET;
            window_reg <= WINDOW_BITS'(WINDOW_RESET);
            chan_reg   <= 2'd2;
            bypass_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DECAY:   decay_reg  <= cfg_data;
                REG_WINDOW:  window_reg <= WINDOW_BITS'(cfg_data);
                REG_CHANNEL: chan_reg   <= cfg_data[1:0];
                REG_BYPASS:  bypass_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front: request queue
    sprm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_item),
        .full    (full),
        .rd_en   (q_take),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    // back: meter engine with its own result register
    logic res_valid;
    sprm_back #(.WINDOW_BITS(WINDOW_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (!q_empty),
        .req        (q_data),
        .req_take   (q_take),
        .decay      (decay_reg),
        .window_len (window_reg),
        .channels   (chan_reg),
        .bypass     (bypass_reg),
        .res_valid  (res_valid),
        .res        (out_item),
        .res_take   (pop)
    );

    assign empty = !res_valid;
endmodule

// ===== rtl/sprm_queue.sv =====
// ----------------------------------------------------------------------------
// sprm_queue
// two-entry request queue between the front and the back
// ----------------------------------------------------------------------------
module sprm_queue
    import sprm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  in_item_t wr_data,
    output logic     full,
    input  logic     rd_en,
    output in_item_t rd_data,
    output logic     empty
);
    in_item_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd_en && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, (wr_en && !full)} - {1'b0, (rd_en && !empty)};
        end
    end
endmodule

// ===== rtl/sprm_back.sv =====
// ----------------------------------------------------------------------------
// sprm_back
// meter engine: peak, square sums, serial divide and square root
// ----------------------------------------------------------------------------
module sprm_back
    import sprm_pkg::*;
#(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  in_item_t               req,
    output logic                   req_take,
    input  logic [DECAY_W-1:0]     decay,
    input  logic [WINDOW_BITS-1:0] window_len,
    input  logic [1:0]             channels,
    input  logic                   bypass,
    output logic                   res_valid,
    output out_item_t              res,
    input  logic                   res_take
);
    localparam int DCNT_W = $clog2(SUM_W + 1);

    back_state_t state_reg, state_next;
    in_item_t    item_reg;
    out_item_t   res_reg;
    logic        res_valid_reg;

    logic [SAMPLE_W-1:0]    peak_reg [2];
    logic [SUM_W-1:0]       sum_reg  [2];
    logic [SAMPLE_W-1:0]    rms_reg  [2];
    logic [WINDOW_BITS-1:0] wcnt_reg;
    logic                   upd_reg;
    logic                   ch_reg;

    // divider / root work registers
    logic [SUM_W-1:0]       quo_reg;
    logic [WINDOW_BITS:0]   rem_reg;
    logic [DCNT_W-1:0]      step_reg;
    logic [SUM_W-1:0]       rad_reg;
    logic [SUM_W-1:0]       root_reg;
    logic [SUM_W-1:0]       bit_reg;

    logic [SAMPLE_W-1:0]          mag;
    logic [2*SAMPLE_W-1:0]        sq;
    logic [SAMPLE_W+DECAY_W-1:0]  dprod;
    logic [SUM_W:0]               sum_add;
    logic                         ch_on;
    logic [WINDOW_BITS-1:0]       win_eff, wcnt_inc;
    logic [WINDOW_BITS:0]         rem_sh;
    logic [SUM_W-1:0]             rtrial;

    assign win_eff  = (window_len == '0) ? WINDOW_BITS'(1) : window_len;
    assign wcnt_inc = wcnt_reg + WINDOW_BITS'(1);

    always_comb
    begin
        logic [SAMPLE_W-1:0] raw;
        raw     = ch_reg ? item_reg.right_sample : item_reg.left_sample;
        mag     = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
        sq      = mag * mag;
        dprod   = peak_reg[ch_reg] * decay;
        sum_add = {1'b0, sum_reg[ch_reg]} + {(SUM_W+1-2*SAMPLE_W)'(0), sq};
        ch_on   = ch_reg ? (channels[1]) : (channels != 2'd0);
        rem_sh  = {rem_reg[WINDOW_BITS-1:0], sum_reg[ch_reg][SUM_W-1 - step_reg]};
        rtrial  = root_reg + bit_reg;
    end

    assign req_take  = (state_reg == ST_IDLE) && req_valid && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_take)
                     begin
                         state_next = (req.kind == KIND_AUDIO && !bypass) ? ST_PEAK : ST_EMIT;
                     end
            ST_PEAK: if (ch_reg)
                     begin
                         state_next = (wcnt_inc >= win_eff) ? ST_DIV : ST_EMIT;
                     end
            ST_DIV:  if (step_reg == DCNT_W'(SUM_W-1)) state_next = ST_SQRT;
            // left root done goes back for the right channel
            ST_SQRT: if (bit_reg == '0)
                     begin
                         state_next = ch_reg ? ST_EMIT : ST_DIV;
                     end
            ST_EMIT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req_take) item_reg <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            peak_reg[0] <= '0; peak_reg[1] <= '0;
            sum_reg[0]  <= '0; sum_reg[1]  <= '0;
            rms_reg[0]  <= '0; rms_reg[1]  <= '0;
            wcnt_reg    <= '0;
            upd_reg     <= 1'b0;
            ch_reg      <= 1'b0;
            step_reg    <= '0;
            quo_reg <= '0; rem_reg <= '0; rad_reg <= '0; root_reg <= '0; bit_reg <= '0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_take && res_valid_reg) res_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    ch_reg  <= 1'b0;
                    upd_reg <= 1'b0;
                    step_reg <= '0;
                    rem_reg <= '0;
                end
                ST_PEAK:
                begin
                    if (ch_on)
                    begin
                        if (mag > peak_reg[ch_reg]) peak_reg[ch_reg] <= mag;
                        else peak_reg[ch_reg] <= dprod[SAMPLE_W+DECAY_W-1:DECAY_W];
                        sum_reg[ch_reg] <= sum_add[SUM_W] ? {SUM_W{1'b1}}
                                                          : sum_add[SUM_W-1:0];
                    end
                    ch_reg <= ~ch_reg;
                    if (ch_reg)
                    begin
                        wcnt_reg <= (wcnt_inc >= win_eff) ? '0 : wcnt_inc;
                    end
                end
                ST_DIV:
                begin
                    // restoring divide, one quotient bit a cycle
                    if (rem_sh >= {1'b0, win_eff})
                    begin
                        rem_reg <= rem_sh - {1'b0, win_eff};
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg + DCNT_W'(1);
                    if (step_reg == DCNT_W'(SUM_W-1))
                    begin
                        rad_reg  <= (rem_sh >= {1'b0, win_eff}) ? {quo_reg[SUM_W-2:0], 1'b1}
                                                                : {quo_reg[SUM_W-2:0], 1'b0};
                        root_reg <= '0;
                        bit_reg  <= {2'b01, {(SUM_W-2){1'b0}}};
                    end
                end
                ST_SQRT:
                begin
                    // digit-by-digit root, two radicand bits a cycle
                    if (bit_reg != '0)
                    begin
                        if (rad_reg >= rtrial)
                        begin
                            rad_reg  <= rad_reg - rtrial;
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                    else
                    begin
                        rms_reg[ch_reg] <= root_reg[SAMPLE_W-1:0];
                        sum_reg[ch_reg] <= '0;
                        upd_reg         <= 1'b1;
                        step_reg        <= '0;
                        rem_reg         <= '0;
                        quo_reg         <= '0;
                        ch_reg          <= ~ch_reg;
                    end
                end
                ST_EMIT:
                begin
                    if (item_reg.kind == KIND_CLR_PEAK || item_reg.kind == KIND_CLR_ALL)
                    begin
                        peak_reg[0] <= '0; peak_reg[1] <= '0;
                    end
                    if (item_reg.kind == KIND_CLR_ALL)
                    begin
                        sum_reg[0] <= '0; sum_reg[1] <= '0;
                        rms_reg[0] <= '0; rms_reg[1] <= '0;
                        wcnt_reg   <= '0;
                    end
                    res_valid_reg     <= 1'b1;
                    res_reg.left_out  <= (item_reg.kind == KIND_AUDIO) ? item_reg.left_sample : '0;
                    res_reg.right_out <= (item_reg.kind == KIND_AUDIO) ? item_reg.right_sample : '0;
                    res_reg.peak_left  <= (item_reg.kind == KIND_CLR_PEAK
                                           || item_reg.kind == KIND_CLR_ALL) ? '0 : peak_reg[0];
                    res_reg.peak_right <= (item_reg.kind == KIND_CLR_PEAK
                                           || item_reg.kind == KIND_CLR_ALL) ? '0 : peak_reg[1];
                    res_reg.rms_left   <= (item_reg.kind == KIND_CLR_ALL) ? '0 : rms_reg[0];
                    res_reg.rms_right  <= (item_reg.kind == KIND_CLR_ALL) ? '0 : rms_reg[1];
                    res_reg.rms_updated <= upd_reg;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/sprm_checker.sv =====
// ----------------------------------------------------------------------------
// sprm_checker
// port-level checks on the level meter
// ----------------------------------------------------------------------------
module sprm_checker
    import sprm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while waiting");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.peak_left <= 24'd8388608 && out_item.peak_right <= 24'd8388608))
        else $error("peak out of range");

    a_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.rms_updated) |-> (out_item.rms_left <= 24'd8388608))
        else $error("rms out of range");
endmodule

bind stereo_peak_rms_meter sprm_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

// ===== verif/stereo_peak_rms_meter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_peak_rms_meter_checker
// watches request, result and register channels, predicts every result
// ----------------------------------------------------------------------------
module stereo_peak_rms_meter_checker
    import sprm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  in_item_t              in_item,
    input  logic                  full,
    input  logic                  empty,
    input  out_item_t             out_item,
    input  logic                  pop,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam logic [61:0] SUM_SAT = '1;

    logic [15:0]       decay_q;
    logic [15:0]       window_q;
    logic [1:0]        chan_q;
    logic              bypass_q;
    logic [23:0]       peak_q [2];
    logic [61:0]       sum_q [2];
    logic [23:0]       rms_q [2];
    logic [15:0]       count_q;
    out_item_t         level_queue [$];

    function automatic logic [23:0] mag_of(logic [23:0] raw);
        return raw[23] ? (~raw + 24'd1) : raw;
    endfunction

    function automatic logic [31:0] root_floor(logic [61:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        logic [63:0] rem;
        root = 0;
        rem  = 64'(v);
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root[31:0];
    endfunction

    task automatic predict_levels(in_item_t req);
        out_item_t   res;
        int          nch;
        logic [16:0] win;
        logic [23:0] m;
        logic [47:0] sq;
        logic [39:0] prod;
        res = '0;
        case (kind_t'(req.kind))
            KIND_AUDIO:
            begin
                res.left_out  = req.left_sample;
                res.right_out = req.right_sample;
                if (!bypass_q)
                begin
                    nch = (chan_q > 2'd2) ? 2 : int'(chan_q);
                    win = (window_q == 0) ? 17'd1 : {1'b0, window_q};
                    for (int ch = 0; ch < nch; ch++)
                    begin
                        m = mag_of(ch == 0 ? req.left_sample : req.right_sample);
                        sq = m * m;
                        if (m > peak_q[ch])
                            peak_q[ch] = m;
                        else
                        begin
                            prod = peak_q[ch] * decay_q;
                            peak_q[ch] = prod[39:16];
                        end
                        if (sum_q[ch] > SUM_SAT - sq)
                            sum_q[ch] = SUM_SAT;
                        else
                            sum_q[ch] = sum_q[ch] + sq;
                    end
                    count_q = count_q + 16'd1;
                    if ({1'b0, count_q} >= win)
                    begin
                        for (int ch = 0; ch < 2; ch++)
                        begin
                            rms_q[ch] = 24'(root_floor(sum_q[ch] / win));
                            sum_q[ch] = '0;
                        end
                        count_q = '0;
                        res.rms_updated = 1'b1;
                    end
                end
            end
            KIND_CLR_PEAK:
            begin
                peak_q[0] = '0;
                peak_q[1] = '0;
            end
            KIND_CLR_ALL:
            begin
                for (int ch = 0; ch < 2; ch++)
                begin
                    peak_q[ch] = '0;
                    sum_q[ch]  = '0;
                    rms_q[ch]  = '0;
                end
                count_q = '0;
            end
            default: ;
        endcase
        res.peak_left  = peak_q[0];
        res.peak_right = peak_q[1];
        res.rms_left   = rms_q[0];
        res.rms_right  = rms_q[1];
        level_queue.push_back(res);
    endtask

    task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r;
        if (!rst_n)
        begin
            decay_q    <= DECAY_RESET;
            window_q   <= WINDOW_RESET;
            chan_q     <= 2'd2;
            bypass_q   <= 1'b0;
            count_q    <= '0;
            for (int ch = 0; ch < 2; ch++)
            begin
                peak_q[ch] <= '0;
                sum_q[ch]  <= '0;
                rms_q[ch]  <= '0;
            end
            fail_count <= 0;
            level_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_reg_t'(cfg_index))
                    REG_DECAY:   decay_q  = cfg_data;
                    REG_WINDOW:  window_q = cfg_data;
                    REG_CHANNEL: chan_q   = cfg_data[1:0];
                    REG_BYPASS:  bypass_q = cfg_data[0];
                    default: ;
                endcase
            if (push && !full)
                predict_levels(in_item);
            if (pop && !empty)
            begin
                if (level_queue.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_r = level_queue.pop_front();
                    check_field("left_out", exp_r.left_out, out_item.left_out);
                    check_field("right_out", exp_r.right_out, out_item.right_out);
                    check_field("peak_left", exp_r.peak_left, out_item.peak_left);
                    check_field("peak_right", exp_r.peak_right, out_item.peak_right);
                    check_field("rms_left", exp_r.rms_left, out_item.rms_left);
                    check_field("rms_right", exp_r.rms_right, out_item.rms_right);
                    check_field("rms_updated", 24'(exp_r.rms_updated),
                                24'(out_item.rms_updated));
                end
            end
        end
    end

    assign pending = level_queue.size();

endmodule

// ===== verif/stereo_peak_rms_meter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_peak_rms_meter_tb
// drives frames, clears and register writes into the level meter with random
// gaps and result stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module stereo_peak_rms_meter_tb;
    import sprm_pkg::*;

    // slowest case: every request closes a window, plus long stalls
    localparam int CYCLE_LIMIT = 2000000;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    in_item_t              in_item;
    logic                  full;
    logic                  empty;
    out_item_t             out_item;
    logic                  pop;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycle_count;
    bit                    pop_enable;

    stereo_peak_rms_meter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .empty     (empty),
        .out_item  (out_item),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stereo_peak_rms_meter_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_item    (in_item),
        .full       (full),
        .empty      (empty),
        .out_item   (out_item),
        .pop        (pop),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // watchdog on a cycle counter
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, with stretches of steady draining
    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!pop_enable)
                pop <= 1'b1;
            else
            begin
                stall = gap_len();
                if (stall > 0)
                begin
                    pop <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                pop <= 1'b1;
            end
        end
    end

    task automatic send_request(logic [1:0] kind, logic [23:0] l, logic [23:0] r);
        in_item_t req;
        req.kind         = kind;
        req.left_sample  = l;
        req.right_sample = r;
        push    <= 1'b1;
        in_item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // request with a random gap before it
    task automatic send_gapped(logic [1:0] kind, logic [23:0] l, logic [23:0] r);
        int g;
        g = pop_enable ? gap_len() : 0;
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(negedge clk);
        end
        send_request(kind, l, r);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // registers change only with the engine drained
    task automatic drain();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (220) @(negedge clk);
    endtask

    function automatic logic [23:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'h000000;
            3: return 24'hffffff;
            4: return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return KIND_AUDIO;
        if (r < 93)
            return KIND_CLR_PEAK;
        if (r < 97)
            return KIND_CLR_ALL;
        return KIND_NONE;
    endfunction

    initial
    begin
        int n_items;
        cycle_count = 0;
        pop_enable  = 1'b0;
        rst_n     = 1'b0;
        push      = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_DECAY;
        cfg_data  = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, equal magnitude, every kind, at reset settings but a window of four
        write_reg(REG_WINDOW, 16'd4);
        send_request(KIND_AUDIO, 24'h800000, 24'h7fffff);
        send_request(KIND_AUDIO, 24'h800000, 24'h800001);
        send_request(KIND_AUDIO, 24'h000000, 24'hffffff);
        send_request(KIND_AUDIO, 24'h400000, 24'hc00000);
        send_request(KIND_CLR_PEAK, 24'h123456, 24'h654321);
        send_request(KIND_AUDIO, 24'h000010, 24'h000010);
        send_request(KIND_AUDIO, 24'h000010, 24'hfffff0);
        send_request(KIND_NONE, 24'h7fffff, 24'h800000);
        send_request(KIND_CLR_ALL, 24'hffffff, 24'hffffff);
        drain();
        // bypass, clears still act under bypass
        write_reg(REG_BYPASS, 16'd1);
        send_request(KIND_AUDIO, 24'h7fffff, 24'h800000);
        send_request(KIND_CLR_ALL, 24'h0, 24'h0);
        drain();
        write_reg(REG_BYPASS, 16'd0);
        // mono, then no channels at all, then channel code three
        write_reg(REG_CHANNEL, 16'd1);
        send_request(KIND_AUDIO, 24'h200000, 24'h7fffff);
        send_request(KIND_AUDIO, 24'h100000, 24'h7fffff);
        drain();
        write_reg(REG_CHANNEL, 16'd0);
        send_request(KIND_AUDIO, 24'h300000, 24'h300000);
        drain();
        write_reg(REG_CHANNEL, 16'd3);
        // window end at the current length, then a shortened window of one
        send_request(KIND_AUDIO, 24'h7fffff, 24'h7fffff);
        drain();
        write_reg(REG_WINDOW, 16'd1);
        send_request(KIND_AUDIO, 24'h000001, 24'h800000);
        drain();
        // zero window acts as one, decay extremes
        write_reg(REG_WINDOW, 16'd0);
        write_reg(REG_DECAY, 16'd0);
        send_request(KIND_AUDIO, 24'h7fffff, 24'h800000);
        send_request(KIND_AUDIO, 24'h000001, 24'h000001);
        drain();
        write_reg(REG_DECAY, 16'hffff);
        send_request(KIND_AUDIO, 24'h7fffff, 24'h800000);
        send_request(KIND_AUDIO, 24'h000001, 24'h000001);
        drain();

        // random phases with varied settings, small windows mostly
        pop_enable = 1'b1;
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_DECAY, (phase == 0) ? 16'hffff :
                                 (phase == 1) ? 16'h0000 : 16'($urandom));
            write_reg(REG_WINDOW, (phase == 7) ? 16'hffff :
                                  16'($urandom_range(0, 12)));
            write_reg(REG_CHANNEL, (phase % 4 == 3) ? 16'($urandom_range(0, 3)) : 16'd2);
            write_reg(REG_BYPASS, (phase == 5) ? 16'd1 : 16'd0);
            n_items = (phase == 7) ? 40 : 60;
            for (int i = 0; i < n_items; i++)
                send_gapped(rand_kind(), rand_sample(), rand_sample());
            drain();
        end

        // a long window that runs to its end, with full-scale samples
        write_reg(REG_WINDOW, 16'd300);
        write_reg(REG_BYPASS, 16'd0);
        for (int i = 0; i < 310; i++)
            send_request(KIND_AUDIO, 24'h800000, 24'h7fffff);
        drain();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sprm_pkg.sv
rtl/sprm_queue.sv
rtl/sprm_back.sv
rtl/stereo_peak_rms_meter.sv
rtl/sprm_checker.sv
verif/stereo_peak_rms_meter_checker.sv
verif/stereo_peak_rms_meter_tb.sv
